// File: rtl/core/ktb_pkg.sv
// ----------------------------------------------------------------------------
// ktb_pkg
// Types and constants shared by the keyed token bucket limiter modules.
// ----------------------------------------------------------------------------
package ktb_pkg;

  localparam int ACT_W      = 2;
  localparam int KEY_W      = 6;
  localparam int TICK_W     = 32;
  localparam int TOK_W      = 32;
  localparam int RATE_W     = 32;
  localparam int BURST_W    = 16;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = TICK_W + RATE_W;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 32'd1311;
  localparam logic [BURST_W-1:0] BURST_RESET = 16'd40;
  localparam logic [TOK_W-1:0]   ONE_TOKEN   = 32'h0001_0000;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_RESET   = 2'd2,
    ACT_EVICT   = 2'd3
  } ktb_action_t;

  // register indexes of the configuration port; index 3 is unused
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE       = 2'd0,
    CFG_BURST      = 2'd1,
    CFG_LIMITER_ON = 2'd2
  } ktb_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACQ_MUL,
    ST_ACQ_SUM,
    ST_ACQ_UPD,
    ST_EV_RD,
    ST_EV_CHK,
    ST_RESP
  } ktb_state_t;

  typedef struct packed {
    logic             valid;
    logic [TOK_W-1:0] tokens;
    logic [TICK_W-1:0] last_tick;
  } ktb_entry_t;

  typedef struct packed {
    logic accept;
    logic tick_inc;
    logic grant_free;
    logic rd_key;
    logic rd_scan;
    logic wr_inval_key;
    logic clr_wr;
    logic acq_mul;
    logic acq_sum;
    logic acq_upd;
    logic ev_chk;
    logic push;
  } ktb_cmd_t;

  typedef struct packed {
    ktb_action_t act;
    logic        limiter_on;
    logic        key_ok;
    logic        scan_last;
    logic        out_free;
  } ktb_status_t;

endpackage

// File: rtl/core/ktb_ctrl.sv
// ----------------------------------------------------------------------------
// ktb_ctrl
// Sequencer for the limiter: clear pass, acquire steps, evict walk, response.
// ----------------------------------------------------------------------------
module ktb_ctrl import ktb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ktb_status_t status,
  output ktb_cmd_t    cmd
);

  ktb_state_t state;
  ktb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.scan_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (status.act)
            ACT_ACQUIRE: begin
              if (status.limiter_on && status.key_ok) begin
                state_next = ST_ACQ_MUL;
              end else begin
                state_next = ST_RESP;
              end
            end
            ACT_EVICT: state_next = ST_EV_RD;
            default:   state_next = ST_RESP;
          endcase
        end
      end
      ST_ACQ_MUL: state_next = ST_ACQ_SUM;
      ST_ACQ_SUM: state_next = ST_ACQ_UPD;
      ST_ACQ_UPD: state_next = ST_RESP;
      ST_EV_RD:   state_next = ST_EV_CHK;
      ST_EV_CHK: begin
        state_next = status.scan_last ? ST_RESP : ST_EV_RD;
      end
      ST_RESP: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (status.act)
            ACT_TICK: cmd.tick_inc = 1'b1;
            ACT_ACQUIRE: begin
              if (!status.limiter_on) begin
                cmd.grant_free = 1'b1;
              end else if (status.key_ok) begin
                cmd.rd_key = 1'b1;
              end
            end
            ACT_RESET: cmd.wr_inval_key = status.key_ok;
            default: ;
          endcase
        end
      end
      ST_ACQ_MUL: cmd.acq_mul = 1'b1;
      ST_ACQ_SUM: cmd.acq_sum = 1'b1;
      ST_ACQ_UPD: cmd.acq_upd = 1'b1;
      ST_EV_RD:   cmd.rd_scan = 1'b1;
      ST_EV_CHK:  cmd.ev_chk  = 1'b1;
      ST_RESP:    cmd.push    = status.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ktb_dp.sv
// ----------------------------------------------------------------------------
// ktb_dp
// Datapath: config registers, tick counter, bucket table, refill arithmetic,
// evict check and output register.
// ----------------------------------------------------------------------------
module ktb_dp import ktb_pkg::*; #(
  parameter int NUM_KEYS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ACT_W-1:0]      action,
  input  logic [KEY_W-1:0]      key_index,
  input  logic [TICK_W-1:0]     max_age,
  input  ktb_cmd_t              cmd,
  output ktb_status_t           status,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  granted,
  output logic [CNT_W-1:0]      evicted_count
);

  localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int KW    = IDX_W + KEY_W;

  // configuration
  logic [RATE_W-1:0]  rate_per_tick;
  logic [BURST_W-1:0] burst_tokens;
  logic               limiter_on;
  logic [TOK_W-1:0]   cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_per_tick <= RATE_RESET;
      burst_tokens  <= BURST_RESET;
      limiter_on    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE:       rate_per_tick <= cfg_data[RATE_W-1:0];
        CFG_BURST:      burst_tokens  <= cfg_data[BURST_W-1:0];
        CFG_LIMITER_ON: limiter_on    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cap = {burst_tokens, 16'h0000};

  // tick counter
  logic [TICK_W-1:0] tick_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now <= '0;
    end else if (cmd.tick_inc) begin
      tick_now <= tick_now + 1'b1;
    end
  end

  // key decode
  logic [KW-1:0]    key_wide;
  logic [IDX_W-1:0] key_in_addr;
  logic             key_ok;

  assign key_wide    = KW'(key_index);
  assign key_in_addr = key_wide[IDX_W-1:0];
  assign key_ok      = 32'(key_index) < 32'(NUM_KEYS);

  logic [IDX_W-1:0]  key_addr;
  logic [TICK_W-1:0] age_max;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_addr <= key_in_addr;
      age_max  <= max_age;
    end
  end

  // scan index for clear pass and evict walk
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;

  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      scan_idx <= '0;
    end else if (cmd.clr_wr || cmd.ev_chk) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  assign scan_last = scan_idx == IDX_W'(NUM_KEYS - 1);

  // bucket table
  ktb_entry_t       mem [NUM_KEYS];
  ktb_entry_t       rdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ktb_entry_t       mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  assign mem_re    = cmd.rd_key || cmd.rd_scan;
  assign mem_raddr = cmd.rd_key ? key_in_addr : scan_idx;

  // refill arithmetic
  logic [TICK_W-1:0] elapsed;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] prod;
  logic [TOK_W-1:0]  tok_base;
  logic [PROD_W-1:0] sum;
  logic [TOK_W-1:0]  tok_cap;
  logic              grant_ok;
  logic [TOK_W-1:0]  tok_left;
  logic              stale;

  // 32x32 product, both operands zero-extended to the full width
  assign elapsed   = tick_now - rdata.last_tick;
  assign prod_next = PROD_W'(elapsed) * PROD_W'(rate_per_tick);

  always_ff @(posedge clk) begin
    if (cmd.acq_mul) begin
      prod     <= rdata.valid ? prod_next : '0;
      tok_base <= rdata.valid ? rdata.tokens : cap;
    end
    if (cmd.acq_sum) begin
      tok_cap <= (sum > PROD_W'(cap)) ? cap : sum[TOK_W-1:0];
    end
  end

  assign sum      = PROD_W'(tok_base) + prod;
  assign grant_ok = tok_cap >= ONE_TOKEN;
  assign tok_left = grant_ok ? tok_cap - ONE_TOKEN : tok_cap;
  assign stale    = rdata.valid && (elapsed > age_max);

  // write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_idx;
    mem_wdata = '0;
    if (cmd.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd.wr_inval_key) begin
      mem_we    = 1'b1;
      mem_waddr = key_in_addr;
    end else if (cmd.acq_upd) begin
      mem_we              = 1'b1;
      mem_waddr           = key_addr;
      mem_wdata.valid     = 1'b1;
      mem_wdata.tokens    = tok_left;
      mem_wdata.last_tick = tick_now;
    end else if (cmd.ev_chk && stale) begin
      mem_we              = 1'b1;
      mem_wdata.tokens    = rdata.tokens;
      mem_wdata.last_tick = rdata.last_tick;
    end
  end

  // result
  logic             res_granted;
  logic [CNT_W-1:0] res_count;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_granted <= cmd.grant_free;
      res_count   <= '0;
    end else begin
      if (cmd.acq_upd) begin
        res_granted <= grant_ok;
      end
      if (cmd.ev_chk && stale && (res_count != CNT_MAX)) begin
        res_count <= res_count + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      granted       <= res_granted;
      evicted_count <= res_count;
    end
  end

  assign status.act        = ktb_action_t'(action);
  assign status.limiter_on = limiter_on;
  assign status.key_ok     = key_ok;
  assign status.scan_last  = scan_last;
  assign status.out_free   = !out_valid || out_ready;

endmodule

// File: rtl/core/keyed_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter
// Per-key token bucket rate limiter. After reset the block clears every
// entry of its bucket table and holds in_ready low meanwhile; configuration
// writes are taken at any time. It then handles one request at a time and
// returns exactly one result per request. A tick, a key reset, an acquire
// with the limiter off or an acquire on an out-of-range key goes from the
// transfer straight to the response state, which pushes its result into the
// output register once that register is free. An enforced acquire steps
// through table read, 32x32 multiply of elapsed ticks by rate, 64-bit add
// and cap against burst, then grant and write-back before its response. An
// evict reads and then checks each table entry in turn through the table's
// read port before its response. Tokens are unsigned 16.16 fixed point;
// an unused bucket starts full at burst_tokens. With limiter_on low every
// acquire is granted and the table is left alone. The result sits in an
// output register, so the next request can be taken while it waits.
// ----------------------------------------------------------------------------
module keyed_token_bucket_limiter import ktb_pkg::*; #(
  parameter int NUM_KEYS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      action,
  input  logic [KEY_W-1:0]      key_index,
  input  logic [TICK_W-1:0]     max_age,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  granted,
  output logic [CNT_W-1:0]      evicted_count
);

  ktb_cmd_t    cmd;
  ktb_status_t status;

  // sequencer: decides steps from request kind and table scan position
  ktb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, tick counter, refill math and result register
  ktb_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .key_index     (key_index),
    .max_age       (max_age),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .granted       (granted),
    .evicted_count (evicted_count)
  );

endmodule

// File: rtl/core/ktb_checker.sv
// ----------------------------------------------------------------------------
// ktb_port_checks
// Port-level checks for the keyed token bucket limiter, bound to the top.
// ----------------------------------------------------------------------------
module ktb_port_checks import ktb_pkg::*; #(
  parameter int NUM_KEYS = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             granted,
  input logic [CNT_W-1:0] evicted_count
);

  localparam int EV_MAX = (NUM_KEYS > 127) ? 127 : NUM_KEYS;

  // one request in flight: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a request transfer");

  // a result carries either a grant or an evict count, never both
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(granted && (evicted_count != '0)))
    else $error("result shows a grant and an evict count together");

  // evict count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(evicted_count) <= EV_MAX))
    else $error("evict count exceeds the number of keys");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(evicted_count))
    else $error("stalled result changed or dropped");

endmodule

bind keyed_token_bucket_limiter ktb_port_checks #(
  .NUM_KEYS (NUM_KEYS)
) u_ktb_port_checks (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .granted       (granted),
  .evicted_count (evicted_count)
);
